// ----- hw/rtl/spq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// shared beat types, command codes and status codes for the priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic               command;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic signed [31:0] removed_priority;
        logic               removed_valid;
        logic [4:0]         entry_count;
        logic [1:0]         status;
    } t_out_beat;

    typedef struct packed {
        logic push;
        logic pop;
        logic load;
    } t_dp_cmd;

endpackage
`default_nettype wire

// ----- hw/rtl/spq_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath
// sorted shift cells with parallel priority compare, lowest-priority entry kept in cell 0,
// plus the registered removed-entry fields of the result beat
// ----------------------------------------------------------------------------
module spq_datapath import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic               i_clk,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic [CW-1:0]      i_count,
    input  wire logic signed [31:0] i_value,
    input  wire logic signed [31:0] i_priority,
    output logic signed [31:0]      o_removed_value,
    output logic signed [31:0]      o_removed_priority,
    output logic                    o_removed_valid
);

    logic signed [31:0] r_val [QUEUE_DEPTH];
    logic signed [31:0] r_pri [QUEUE_DEPTH];
    logic signed [31:0] n_val [QUEUE_DEPTH];
    logic signed [31:0] n_pri [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] lt;

    logic signed [31:0] r_rm_val;
    logic signed [31:0] r_rm_pri;
    logic               r_rm_valid;

    // cell i holds a live entry below the incoming priority
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            lt[i] = (CW'(i) < i_count) && (r_pri[i] < i_priority);
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_val[i] = r_val[i];
            n_pri[i] = r_pri[i];
            if (i_cmd.push) begin
                if (lt[i]) begin
                    n_val[i] = r_val[i];
                    n_pri[i] = r_pri[i];
                end else if (i == 0) begin
                    n_val[i] = i_value;
                    n_pri[i] = i_priority;
                end else if (lt[i-1]) begin
                    n_val[i] = i_value;
                    n_pri[i] = i_priority;
                end else begin
                    n_val[i] = r_val[i-1];
                    n_pri[i] = r_pri[i-1];
                end
            end else if (i_cmd.pop && (i < QUEUE_DEPTH - 1)) begin
                n_val[i] = r_val[i+1];
                n_pri[i] = r_pri[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_val[i] <= n_val[i];
            r_pri[i] <= n_pri[i];
        end
        if (i_cmd.load) begin
            r_rm_val   <= i_cmd.pop ? r_val[0] : 32'sd0;
            r_rm_pri   <= i_cmd.pop ? r_pri[0] : 32'sd0;
            r_rm_valid <= i_cmd.pop;
        end
    end

    assign o_removed_value    = r_rm_val;
    assign o_removed_priority = r_rm_pri;
    assign o_removed_valid    = r_rm_valid;

endmodule
`default_nettype wire

// ----- hw/rtl/spq_controller.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_controller
// handshake control, entry count, status decode and datapath commands
// ----------------------------------------------------------------------------
module spq_controller import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16,
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_command,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output t_dp_cmd            o_cmd,
    output logic [CW-1:0]      o_count,
    output logic [1:0]         o_status
);

    typedef enum logic {
        ST_IDLE,
        ST_HOLD
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_status, n_status;
    logic          accept, full, empty;

    assign full   = (r_count == CW'(QUEUE_DEPTH));
    assign empty  = (r_count == '0);
    assign accept = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.load = accept;
        o_cmd.push = accept && (i_command == CMD_PUSH) && !full;
        o_cmd.pop  = accept && (i_command == CMD_POP) && !empty;
        n_count    = r_count;
        n_status   = r_status;
        if (accept) begin
            if (i_command == CMD_PUSH) begin
                n_status = full ? STATUS_FULL : STATUS_OK;
                if (!full) n_count = r_count + 1'b1;
            end else begin
                n_status = empty ? STATUS_EMPTY : STATUS_OK;
                if (!empty) n_count = r_count - 1'b1;
            end
        end
        case (r_state)
            ST_IDLE: n_state = accept ? ST_HOLD : ST_IDLE;
            ST_HOLD: n_state = (accept || !i_out_ready) ? ST_HOLD : ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_status <= n_status;
    end

    // no beat is taken while reset is held
    assign o_in_ready  = i_rst_n && ((r_state == ST_IDLE) || i_out_ready);
    assign o_out_valid = (r_state == ST_HOLD);
    assign o_count     = r_count;
    assign o_status    = r_status;

endmodule
`default_nettype wire

// ----- hw/rtl/sorted_priority_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue
// sorted-list priority queue of up to QUEUE_DEPTH value/priority entries
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_ready / i_in_beat) carries push or pop
//   commands; every accepted beat yields exactly one result beat on the
//   output channel (o_out_valid / i_out_ready / o_out_beat)
//   push inserts ahead of all entries of equal or higher priority; a push into
//   a full queue is refused with status full and no change
//   pop removes the lowest-priority, latest entry; a pop on an empty queue
//   returns status empty with zeroed removed fields
//   a result is valid in the cycle after its accept; throughput is 1 beat
//   per cycle unless the receiver stalls, via parallel compare and shift of the cells
//   the output register holds a result while the receiver stalls; a new
//   command is taken in the same cycle the held result is taken
//   reset clears the count and output valid; cell contents need no clearing
// ----------------------------------------------------------------------------
module sorted_priority_queue import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_beat
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_dp_cmd       cmd;
    logic [CW-1:0] count;
    logic [1:0]    status;

    spq_controller #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_in_beat.command),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .o_count     (count),
        .o_status    (status)
    );

    spq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CW          (CW)
    ) u_dp (
        .i_clk              (i_clk),
        .i_cmd              (cmd),
        .i_count            (count),
        .i_value            (i_in_beat.item_value),
        .i_priority         (i_in_beat.item_priority),
        .o_removed_value    (o_out_beat.removed_value),
        .o_removed_priority (o_out_beat.removed_priority),
        .o_removed_valid    (o_out_beat.removed_valid)
    );

    assign o_out_beat.entry_count = 5'(count);
    assign o_out_beat.status      = status;

endmodule
`default_nettype wire
